// ----- hw/rtl/nbp_pkg.sv -----
// Package for the nine-bit word byte packer: widths, codes and request types.
package nbp_pkg;

  localparam int unsigned WordW         = 9;
  localparam int unsigned ByteW         = 8;
  localparam int unsigned FrameBytes    = 9;
  localparam int unsigned WordsPerFrame = 8;
  localparam int unsigned FrameW        = FrameBytes * ByteW;
  localparam int unsigned CountW        = $clog2(WordsPerFrame);
  localparam int unsigned ByteIdxW      = $clog2(FrameBytes);
  localparam int unsigned ShiftW        = $clog2(FrameW);

  // Request kind codes
  localparam logic KindWord  = 1'b0;
  localparam logic KindFlush = 1'b1;

  // Index of the last word and last byte of a frame
  localparam logic [CountW-1:0]   LastWord = CountW'(WordsPerFrame - 1);
  localparam logic [ByteIdxW-1:0] LastByte = ByteIdxW'(FrameBytes - 1);

  typedef struct packed {
    logic             kind;
    logic [WordW-1:0] word;
  } in_req_t;

  typedef struct packed {
    logic [ByteW-1:0] byte_out;
    logic             last;
  } out_req_t;

  // Frame handoff from packer to emitter
  typedef struct packed {
    logic              load;
    logic [FrameW-1:0] frame;
  } frame_load_t;

endpackage

// ----- hw/rtl/nbp_packer.sv -----
// Input register and frame packing state of the nine-bit word byte packer.
module nbp_packer (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  nbp_pkg::in_req_t         in_req_i,
  input  logic                     emit_free_i,
  output nbp_pkg::frame_load_t     load_o
);

  nbp_pkg::in_req_t                 in_q;
  logic                             in_vld_q, in_vld_d;
  logic [nbp_pkg::FrameW-1:0]       frame_q, frame_d;
  logic [nbp_pkg::CountW-1:0]       count_q, count_d;

  logic [nbp_pkg::FrameW-1:0]       packed_frame;
  logic [nbp_pkg::ShiftW-1:0]       shift_amt;
  logic                             emit_needed;
  logic                             adv;

  // Word lands at bit 9*count from the top of the frame, MSB first
  assign shift_amt    = nbp_pkg::ShiftW'({count_q, 3'b000}) + nbp_pkg::ShiftW'(count_q);
  assign packed_frame = frame_q
                      | ({in_q.word, {(nbp_pkg::FrameW - nbp_pkg::WordW){1'b0}}} >> shift_amt);

  // A flush or the eighth word hands a frame to the emitter
  assign emit_needed = (in_q.kind == nbp_pkg::KindFlush) || (count_q == nbp_pkg::LastWord);
  assign adv         = in_vld_q && (!emit_needed || emit_free_i);
  assign in_ready_o  = !in_vld_q || adv;

  always_comb begin
    load_o.load  = adv && emit_needed;
    load_o.frame = (in_q.kind == nbp_pkg::KindFlush) ? frame_q : packed_frame;
  end

  // Next frame state
  always_comb begin
    frame_d  = frame_q;
    count_d  = count_q;
    in_vld_d = in_vld_q;
    if (adv) begin
      in_vld_d = 1'b0;
      if (emit_needed) begin
        frame_d = '0;
        count_d = '0;
      end else begin
        frame_d = packed_frame;
        count_d = count_q + 1'b1;
      end
    end
    if (in_valid_i && in_ready_o) begin
      in_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      frame_q  <= '0;
      count_q  <= '0;
    end else begin
      in_vld_q <= in_vld_d;
      frame_q  <= frame_d;
      count_q  <= count_d;
    end
  end

  // Input payload register
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_req_i;
    end
  end

endmodule

// ----- hw/rtl/nbp_emitter.sv -----
// Byte emitter: shifts a loaded 72-bit frame out as nine byte requests.
module nbp_emitter (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  nbp_pkg::frame_load_t load_i,
  output logic                 emit_free_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output nbp_pkg::out_req_t    out_req_o
);

  logic [nbp_pkg::FrameW-1:0]   buf_q, buf_d;
  logic [nbp_pkg::ByteIdxW-1:0] idx_q, idx_d;
  logic                         busy_q, busy_d;
  logic                         pop, pop_last;

  assign pop      = busy_q && out_ready_i;
  assign pop_last = pop && (idx_q == nbp_pkg::LastByte);

  // Free when idle or when the final byte leaves this cycle
  assign emit_free_o = !busy_q || pop_last;

  assign out_valid_o        = busy_q;
  assign out_req_o.byte_out = buf_q[nbp_pkg::FrameW-1 -: nbp_pkg::ByteW];
  assign out_req_o.last     = (idx_q == nbp_pkg::LastByte);

  always_comb begin
    buf_d  = buf_q;
    idx_d  = idx_q;
    busy_d = busy_q;
    if (pop) begin
      buf_d = {buf_q[nbp_pkg::FrameW-nbp_pkg::ByteW-1:0], {nbp_pkg::ByteW{1'b0}}};
      idx_d = idx_q + 1'b1;
      if (pop_last) begin
        busy_d = 1'b0;
      end
    end
    if (load_i.load) begin
      buf_d  = load_i.frame;
      idx_d  = '0;
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  // Frame shift register, payload only
  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

endmodule

// ----- hw/rtl/nine_bit_word_byte_packer.sv -----
// Top level of the nine-bit word byte packer.
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_req_i): each request is either a
//   9-bit word to pack (kind = word) or a flush (kind = flush, word ignored).
//   Words are packed MSB first into a 72-bit frame of nine bytes.
//   Output channel (out_valid_o/out_ready_i/out_req_o): one byte per request,
//   last set on the ninth byte of each frame.
// Path: a request is registered on acceptance and packed from the input
//   register; the frame shift register then offers a completed frame's first
//   byte, and one byte per cycle while the receiver is ready.
// Throughput: one input request per cycle while no frame is pending. Each
//   frame stays on the output shift register until its nine bytes have left,
//   and a flush also sends a full frame of nine bytes.
// Reset: frame buffer and word count clear to zero, no output pending.
// Stall: while the receiver holds off, the emitter keeps its frame; words
//   that do not complete a frame are still taken, and the request that
//   would complete the next frame waits in the input register.
module nine_bit_word_byte_packer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  nbp_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output nbp_pkg::out_req_t out_req_o
);

  nbp_pkg::frame_load_t load;
  logic                 emit_free;

  nbp_packer u_packer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .emit_free_i (emit_free),
    .load_o      (load)
  );

  nbp_emitter u_emitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .emit_free_o (emit_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_req_o   (out_req_o)
  );

`ifndef SYNTHESIS
  // A frame is only handed over when the emitter can take it
  assert property (@(posedge clk_i) disable iff (!rst_ni) load.load |-> emit_free)
    else $error("frame loaded while emitter busy");

  // Input backpressure only arises while bytes are pending
  assert property (@(posedge clk_i) disable iff (!rst_ni) !in_ready_o |-> out_valid_o)
    else $error("input stalled with emitter idle");

  // After the last byte leaves with no new frame, the output goes idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && out_req_o.last && !load.load) |=> !out_valid_o)
    else $error("output valid after frame end");
`endif

endmodule
